@@ sv/vasa_pkg.sv @@
// Shared types and constants for the voice activity squelch adjuster.
package vasa_pkg;

    localparam int RSSI_W   = 9;
    localparam int LEVEL_W  = 8;
    localparam int SCORE_W  = 7;
    localparam int ADJ_W    = 4;
    localparam int WORD_W   = 16;
    localparam int HOLD_W   = 5;

    localparam logic [LEVEL_W-1:0] OPEN_RESET   = 8'd110;
    localparam logic [LEVEL_W-1:0] CLOSE_RESET  = 8'd100;
    localparam logic [RSSI_W-1:0]  RSSI_RESET   = 9'd0;
    localparam logic [LEVEL_W-1:0] NOISE_RESET  = 8'd127;
    localparam logic [LEVEL_W-1:0] GLITCH_RESET = 8'd255;

    localparam logic [SCORE_W-1:0] SCORE_MAX  = 7'd100;
    localparam logic [SCORE_W-1:0] SCORE_HOLD = 7'd50;
    localparam logic [SCORE_W-1:0] SCORE_HIGH = 7'd70;
    localparam logic [SCORE_W-1:0] SCORE_MID  = 7'd30;
    localparam logic [SCORE_W-1:0] SCORE_LOW  = 7'd15;

    localparam logic signed [ADJ_W-1:0] ADJ_TIGHT_HI = -4'sd6;
    localparam logic signed [ADJ_W-1:0] ADJ_TIGHT_LO = -4'sd3;
    localparam logic signed [ADJ_W-1:0] ADJ_NONE     = 4'sd0;
    localparam logic signed [ADJ_W-1:0] ADJ_LOOSE_LO = 4'sd2;
    localparam logic signed [ADJ_W-1:0] ADJ_LOOSE_HI = 4'sd4;

    // Register indexes on the configuration channel.
    localparam logic CFG_OPEN  = 1'b0;
    localparam logic CFG_CLOSE = 1'b1;

    typedef struct packed {
        logic [SCORE_W-1:0]       voice_score;
        logic signed [ADJ_W-1:0]  step_adjust;
        logic                     write_strobe;
        logic [WORD_W-1:0]        threshold_word;
    } result_t;

endpackage

@@ sv/voice_activity_squelch_adjust_core.sv @@
// Top level of the voice activity squelch adjuster with stream and config ports.
// Each accepted beat is held in the input register, and its result in the result register.
// Throughput: one input beat per cycle while the result side is not stalled; the
// smoothing, scoring and threshold pass lies between the input and result registers.
// Inactive ticks are consumed without a result beat. Reset (rst_n low) clears
// the averages to 0, 127 and 255, the hangover count, the previous adjustment,
// and loads the open and close thresholds with 110 and 100.
module voice_activity_squelch_adjust_core #(
    parameter int HOLD_TICKS = 20,
    parameter int AVG_SHIFT  = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [8:0] rssi_sample, [16:9] noise_sample, [24:17] glitch_sample, rest zero
    input  logic [31:0] s_axis_tdata,
    // [0] rx_active
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] voice_score, [10:7] step_adjust, [26:11] threshold_word, rest zero
    output logic [31:0] m_axis_tdata,
    // [0] write_strobe
    output logic [0:0]  m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    // Configuration registers. Writes are always taken.
    logic [vasa_pkg::LEVEL_W-1:0] open_reg;
    logic [vasa_pkg::LEVEL_W-1:0] close_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= vasa_pkg::OPEN_RESET;
            close_reg <= vasa_pkg::CLOSE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vasa_pkg::CFG_OPEN:  open_reg  <= cfg_data;
                vasa_pkg::CFG_CLOSE: close_reg <= cfg_data;
                default:             open_reg  <= open_reg;
            endcase
        end
    end

    // Input register stage. A held beat leaves once its result can be taken;
    // an inactive beat leaves at once since it produces nothing.
    logic                         in_valid_reg;
    logic                         in_active_reg;
    logic [vasa_pkg::RSSI_W-1:0]  in_rssi_reg;
    logic [vasa_pkg::LEVEL_W-1:0] in_noise_reg;
    logic [vasa_pkg::LEVEL_W-1:0] in_glitch_reg;

    logic out_free;
    logic in_done;
    logic commit;

    logic                     out_valid_reg;
    vasa_pkg::result_t        out_reg;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_done       = in_valid_reg && (!in_active_reg || out_free);
    assign commit        = in_done && in_active_reg;
    assign s_axis_tready = !in_valid_reg || in_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_active_reg <= s_axis_tuser[0];
            in_rssi_reg   <= s_axis_tdata[8:0];
            in_noise_reg  <= s_axis_tdata[16:9];
            in_glitch_reg <= s_axis_tdata[24:17];
        end
    end

    // Running state, updated only when an active tick commits its result.
    logic [vasa_pkg::RSSI_W-1:0]        rssi_avg_reg;
    logic [vasa_pkg::LEVEL_W-1:0]       noise_avg_reg;
    logic [vasa_pkg::LEVEL_W-1:0]       glitch_avg_reg;
    logic [vasa_pkg::HOLD_W-1:0]        hold_reg;
    logic                               last_valid_reg;
    logic signed [vasa_pkg::ADJ_W-1:0]  last_adj_reg;

    logic [vasa_pkg::RSSI_W-1:0]        rssi_avg_next;
    logic [vasa_pkg::LEVEL_W-1:0]       noise_avg_next;
    logic [vasa_pkg::LEVEL_W-1:0]       glitch_avg_next;
    logic [vasa_pkg::HOLD_W-1:0]        hold_next;
    vasa_pkg::result_t                  result_next;

    vasa_smooth #(
        .WIDTH (vasa_pkg::RSSI_W),
        .SHIFT (AVG_SHIFT)
    ) u_rssi_avg (
        .old_avg (rssi_avg_reg),
        .sample  (in_rssi_reg),
        .new_avg (rssi_avg_next)
    );

    vasa_smooth #(
        .WIDTH (vasa_pkg::LEVEL_W),
        .SHIFT (AVG_SHIFT)
    ) u_noise_avg (
        .old_avg (noise_avg_reg),
        .sample  (in_noise_reg),
        .new_avg (noise_avg_next)
    );

    vasa_smooth #(
        .WIDTH (vasa_pkg::LEVEL_W),
        .SHIFT (AVG_SHIFT)
    ) u_glitch_avg (
        .old_avg (glitch_avg_reg),
        .sample  (in_glitch_reg),
        .new_avg (glitch_avg_next)
    );

    // The score is taken from the freshly smoothed values of this tick.
    vasa_score #(
        .HOLD_TICKS (HOLD_TICKS)
    ) u_score (
        .rssi_avg        (rssi_avg_next),
        .noise_avg       (noise_avg_next),
        .glitch_avg      (glitch_avg_next),
        .open_threshold  (open_reg),
        .close_threshold (close_reg),
        .hold_count      (hold_reg),
        .last_valid      (last_valid_reg),
        .last_adjust     (last_adj_reg),
        .hold_next       (hold_next),
        .result          (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rssi_avg_reg   <= vasa_pkg::RSSI_RESET;
            noise_avg_reg  <= vasa_pkg::NOISE_RESET;
            glitch_avg_reg <= vasa_pkg::GLITCH_RESET;
            hold_reg       <= '0;
            last_valid_reg <= 1'b0;
            last_adj_reg   <= vasa_pkg::ADJ_NONE;
        end
        else if (commit)
        begin
            rssi_avg_reg   <= rssi_avg_next;
            noise_avg_reg  <= noise_avg_next;
            glitch_avg_reg <= glitch_avg_next;
            hold_reg       <= hold_next;
            last_valid_reg <= 1'b1;
            last_adj_reg   <= result_next.step_adjust;
        end
    end

    // Result register. It holds a beat until the master side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            out_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.threshold_word, out_reg.step_adjust,
                            out_reg.voice_score};
    assign m_axis_tuser  = out_reg.write_strobe;

endmodule

@@ sv/vasa_smooth.sv @@
// Exponential average update with an arithmetic shift of the signed difference.
module vasa_smooth #(
    parameter int WIDTH = 8,
    parameter int SHIFT = 3
) (
    input  logic [WIDTH-1:0] old_avg,
    input  logic [WIDTH-1:0] sample,
    output logic [WIDTH-1:0] new_avg
);

    logic signed [WIDTH:0] diff;
    logic signed [WIDTH:0] step;
    logic [WIDTH:0]        sum;

    // The shift floors toward minus infinity, as the average requires.
    assign diff    = $signed({1'b0, sample}) - $signed({1'b0, old_avg});
    assign step    = diff >>> SHIFT;
    assign sum     = {1'b0, old_avg} + $unsigned(step);
    assign new_avg = sum[WIDTH-1:0];

endmodule

@@ sv/vasa_score.sv @@
// Voice score, hangover, step adjustment and threshold word for one tick.
module vasa_score #(
    parameter int HOLD_TICKS = 20
) (
    input  logic [vasa_pkg::RSSI_W-1:0]      rssi_avg,
    input  logic [vasa_pkg::LEVEL_W-1:0]     noise_avg,
    input  logic [vasa_pkg::LEVEL_W-1:0]     glitch_avg,
    input  logic [vasa_pkg::LEVEL_W-1:0]     open_threshold,
    input  logic [vasa_pkg::LEVEL_W-1:0]     close_threshold,
    input  logic [vasa_pkg::HOLD_W-1:0]      hold_count,
    input  logic                             last_valid,
    input  logic signed [vasa_pkg::ADJ_W-1:0] last_adjust,
    output logic [vasa_pkg::HOLD_W-1:0]      hold_next,
    output vasa_pkg::result_t                result
);

    localparam logic [vasa_pkg::HOLD_W-1:0] HOLD_LOAD = vasa_pkg::HOLD_W'(HOLD_TICKS);
    localparam logic [vasa_pkg::HOLD_W-1:0] HOLD_ONE  = vasa_pkg::HOLD_W'(1);

    logic signed [7:0]                 s;
    logic signed [9:0]                 snr;
    logic [vasa_pkg::SCORE_W-1:0]      raw_score;
    logic [vasa_pkg::SCORE_W-1:0]      score;
    logic signed [vasa_pkg::ADJ_W-1:0] adj;
    logic signed [vasa_pkg::ADJ_W-1:0] safe;
    logic signed [9:0]                 open_sum;
    logic signed [9:0]                 close_sum;
    logic [7:0]                        open_byte;
    logic [7:0]                        close_byte;
    logic                              strobe;

    always_comb
    begin
        s   = 8'sd0;
        snr = $signed({1'b0, rssi_avg}) - $signed({2'b00, close_threshold});

        if (noise_avg < 8'd30)
            s = s + 8'sd35;
        else if (noise_avg < 8'd60)
            s = s + 8'sd25;
        else if (noise_avg < 8'd100)
            s = s + 8'sd10;
        else if (noise_avg > 8'd200)
            s = s - 8'sd15;

        if (glitch_avg < 8'd15)
            s = s + 8'sd20;
        else if (glitch_avg < 8'd40)
            s = s + 8'sd10;
        else if (glitch_avg > 8'd150)
            s = s - 8'sd20;
        else if (glitch_avg > 8'd80)
            s = s - 8'sd5;

        if (snr > 10'sd25)
            s = s + 8'sd25;
        else if (snr > 10'sd15)
            s = s + 8'sd15;
        else if (snr > 10'sd8)
            s = s + 8'sd5;
        else
            s = s - 8'sd10;

        // Cross terms: clean channel with some activity, and a dirty channel.
        if (noise_avg < 8'd60 && glitch_avg < 8'd40 && glitch_avg > 8'd5)
            s = s + 8'sd10;
        if (noise_avg > 8'd150 && glitch_avg > 8'd100)
            s = s - 8'sd10;

        if (s < 8'sd0)
            raw_score = '0;
        else if (s > 8'sd100)
            raw_score = vasa_pkg::SCORE_MAX;
        else
            raw_score = s[vasa_pkg::SCORE_W-1:0];
    end

    always_comb
    begin
        score     = raw_score;
        hold_next = hold_count;
        if (raw_score >= vasa_pkg::SCORE_HOLD)
        begin
            hold_next = HOLD_LOAD;
        end
        else if (hold_count != '0)
        begin
            hold_next = hold_count - HOLD_ONE;
            score     = vasa_pkg::SCORE_HOLD;
        end
    end

    always_comb
    begin
        if (score >= vasa_pkg::SCORE_HIGH)
            adj = vasa_pkg::ADJ_TIGHT_HI;
        else if (score >= vasa_pkg::SCORE_HOLD)
            adj = vasa_pkg::ADJ_TIGHT_LO;
        else if (score >= vasa_pkg::SCORE_MID)
            adj = vasa_pkg::ADJ_NONE;
        else if (score >= vasa_pkg::SCORE_LOW)
            adj = vasa_pkg::ADJ_LOOSE_LO;
        else
            adj = vasa_pkg::ADJ_LOOSE_HI;
    end

    // Thresholds only ever move down; a positive step writes them unchanged.
    assign safe      = adj[vasa_pkg::ADJ_W-1] ? adj : vasa_pkg::ADJ_NONE;
    assign open_sum  = $signed({2'b00, open_threshold}) + 10'(safe);
    assign close_sum = $signed({2'b00, close_threshold}) + 10'(safe);
    assign open_byte  = open_sum[9] ? 8'd0 : open_sum[7:0];
    assign close_byte = close_sum[9] ? 8'd0 : close_sum[7:0];

    assign strobe = !last_valid || (adj != last_adjust);

    assign result.voice_score    = score;
    assign result.step_adjust    = adj;
    assign result.write_strobe   = strobe;
    assign result.threshold_word = strobe ? {open_byte, close_byte} : '0;

endmodule

@@ tb/sv/squelch_checker.sv @@
`timescale 1ns / 100ps
// Checker for the squelch adjuster: watches all channels, predicts and compares result beats.
module squelch_checker
    import vasa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          outstanding
);

    localparam int HOLD_TICKS = 20;
    localparam int AVG_SHIFT  = 3;

    // Own copy of the thresholds and of the smoothing and hangover state.
    int open_level;
    int close_level;
    int rssi_avg;
    int noise_avg;
    int glitch_avg;
    int hangover_left;
    int prev_adjust;
    int error_total;

    result_t squelch_outcomes[$];

    // Exponential average with a floor shift of the signed difference.
    function automatic int ema_step(input int prev, input int sample);
        int diff;
        diff = sample - prev;
        return prev + (diff >>> AVG_SHIFT);
    endfunction

    function automatic int voice_score_of(input int rssi, input int noise, input int glitch,
                                          input int floor_level);
        int s;
        int snr;
        s = 0;
        if (noise < 30)       s += 35;
        else if (noise < 60)  s += 25;
        else if (noise < 100) s += 10;
        else if (noise > 200) s -= 15;

        if (glitch < 15)       s += 20;
        else if (glitch < 40)  s += 10;
        else if (glitch > 150) s -= 20;
        else if (glitch > 80)  s -= 5;

        snr = rssi - floor_level;
        if (snr > 25)      s += 25;
        else if (snr > 15) s += 15;
        else if (snr > 8)  s += 5;
        else               s -= 10;

        if (noise < 60 && glitch < 40 && glitch > 5) s += 10;
        if (noise > 150 && glitch > 100) s -= 10;

        if (s < 0) s = 0;
        if (s > int'(SCORE_MAX)) s = int'(SCORE_MAX);
        return s;
    endfunction

    function automatic logic signed [ADJ_W-1:0] adjust_of_score(input int score);
        if (score >= int'(SCORE_HIGH)) return ADJ_TIGHT_HI;
        if (score >= int'(SCORE_HOLD)) return ADJ_TIGHT_LO;
        if (score >= int'(SCORE_MID))  return ADJ_NONE;
        if (score >= int'(SCORE_LOW))  return ADJ_LOOSE_LO;
        return ADJ_LOOSE_HI;
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_level(input int v);
        if (v < 0)   return '0;
        if (v > 255) return '1;
        return v[LEVEL_W-1:0];
    endfunction

    task automatic predict_tick(input int rssi, input int noise, input int glitch);
        result_t r;
        int score;
        int cut;
        logic signed [ADJ_W-1:0] adj;
        rssi_avg   = ema_step(rssi_avg, rssi);
        noise_avg  = ema_step(noise_avg, noise);
        glitch_avg = ema_step(glitch_avg, glitch);
        score = voice_score_of(rssi_avg, noise_avg, glitch_avg, close_level);
        if (score >= int'(SCORE_HOLD))
        begin
            hangover_left = HOLD_TICKS;
        end
        else if (hangover_left > 0)
        begin
            hangover_left--;
            score = int'(SCORE_HOLD);
        end
        adj = adjust_of_score(score);
        r.voice_score    = score[SCORE_W-1:0];
        r.step_adjust    = adj;
        r.write_strobe   = 1'b0;
        r.threshold_word = '0;
        if (int'(adj) != prev_adjust)
        begin
            // Tighten-only: a positive step leaves the thresholds as they are.
            prev_adjust = int'(adj);
            cut = (adj < 0) ? int'(adj) : 0;
            r.write_strobe   = 1'b1;
            r.threshold_word = {clamp_level(open_level + cut), clamp_level(close_level + cut)};
        end
        squelch_outcomes.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            error_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_level    = int'(OPEN_RESET);
            close_level   = int'(CLOSE_RESET);
            rssi_avg      = int'(RSSI_RESET);
            noise_avg     = int'(NOISE_RESET);
            glitch_avg    = int'(GLITCH_RESET);
            hangover_left = 0;
            prev_adjust   = 127;
            error_total   = 0;
            squelch_outcomes.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OPEN)
                    open_level = int'(cfg_data);
                else
                    close_level = int'(cfg_data);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (squelch_outcomes.size() == 0)
                begin
                    error_total++;
                    $display("%0t: result beat with none expected, actual data %h strobe %0d",
                             $time, m_axis_tdata, m_axis_tuser[0]);
                end
                else
                begin
                    result_t want;
                    want = squelch_outcomes.pop_front();
                    check_field("voice_score", int'(want.voice_score), int'(m_axis_tdata[6:0]));
                    check_field("step_adjust", int'(want.step_adjust),
                                int'($signed(m_axis_tdata[10:7])));
                    check_field("write_strobe", int'(want.write_strobe), int'(m_axis_tuser[0]));
                    check_field("threshold_word", int'(want.threshold_word),
                                int'(m_axis_tdata[26:11]));
                end
            end
            if (s_axis_tvalid && s_axis_tready && s_axis_tuser[0])
                predict_tick(int'(s_axis_tdata[8:0]), int'(s_axis_tdata[16:9]),
                             int'(s_axis_tdata[24:17]));
            mismatches  <= error_total;
            outstanding <= squelch_outcomes.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Top of the squelch adjuster testbench: clock, reset, stimulus, stall control and verdict.
module tb;
    import vasa_pkg::*;

    // The longest legitimate stretch without any accepted beat is the forced
    // receiver hold-off plus a short run of random stalls, so a quiet period
    // of this many cycles can only mean the block has hung.
    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int PHASE_TICKS     = 65;
    localparam int NUM_PHASES      = 8;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    int mismatches;
    int outstanding;

    // Percentages for random gaps on the input side and random stalls on the
    // result side, and the request counter for the long receiver hold-off.
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_asks;
    int hold_seen;
    int hold_left;
    int quiet_cycles;

    // Current base thresholds, used to aim the RSSI of the random runs
    // around the close threshold where the SNR bands sit.
    int open_cfg;
    int close_cfg;

    voice_activity_squelch_adjust_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    squelch_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always #4 clk = ~clk;

    // Result-side ready. A new hold-off request loads a cycle counter that
    // keeps ready low for the whole stretch; otherwise ready follows the
    // stall percentage of the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_seen     <= 0;
            hold_left     <= 0;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen     <= hold_asks;
            hold_left     <= HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: any accepted beat on any channel restarts the count.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offers one tick on the input stream, after a random number of idle
    // cycles, and returns at the edge where the beat is taken. Valid stays
    // high into the next call when no gap is drawn.
    task automatic send_tick(input bit active, input logic [8:0] rssi,
                             input logic [7:0] noise, input logic [7:0] glitch);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, glitch, noise, rssi};
        s_axis_tuser  <= active;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // The checker registers its count of expected beats, so the task waits
    // for a clock edge before the count is trusted.
    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Writes both thresholds back to back; valid stays high between the two
    // beats and drops once the second one is taken.
    task automatic write_thresholds(input int open_value, input int close_value);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_OPEN;
        cfg_data  <= open_value[7:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_CLOSE;
        cfg_data  <= close_value[7:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        open_cfg  = open_value;
        close_cfg = close_value;
    endtask

    // Random traffic as runs of one signal character, so the slow averages
    // settle and the score walks through every band, the hangover and every
    // step. Each run mixes in skipped ticks and fully random readings.
    task automatic random_phase(input int n_active);
        int sent;
        int run_len;
        int kind;
        int lo;
        bit active;
        logic [8:0] rssi;
        logic [7:0] noise;
        logic [7:0] glitch;
        sent = 0;
        while (sent < n_active)
        begin
            kind    = $urandom_range(9);
            run_len = $urandom_range(40, 4);
            repeat (run_len)
            begin
                active = ($urandom_range(99) >= 10);
                rssi   = 9'($urandom_range(511));
                noise  = 8'($urandom_range(255));
                glitch = 8'($urandom_range(255));
                if (active && $urandom_range(99) >= 8)
                begin
                    if (kind <= 3)
                    begin
                        // Clean voice: strong carrier, quiet noise, few glitches.
                        lo     = (close_cfg + 16 > 511) ? 511 : close_cfg + 16;
                        rssi   = 9'($urandom_range(511, lo));
                        noise  = 8'($urandom_range(45));
                        glitch = 8'($urandom_range(38, 3));
                    end
                    else if (kind <= 6)
                    begin
                        // Open channel noise: weak carrier, heavy noise and glitches.
                        rssi   = 9'($urandom_range(close_cfg + 12, 0));
                        noise  = 8'($urandom_range(255, 140));
                        glitch = 8'($urandom_range(255, 90));
                    end
                    else if (kind <= 8)
                    begin
                        // Marginal signal around the SNR and noise band edges.
                        rssi   = 9'($urandom_range(close_cfg + 30, close_cfg));
                        noise  = 8'($urandom_range(130, 40));
                        glitch = 8'($urandom_range(120, 10));
                    end
                end
                send_tick(active, rssi, noise, glitch);
                if (active)
                    sent++;
                if (sent >= n_active)
                    break;
            end
        end
    endtask

    initial
    begin
        int open_list[NUM_PHASES];
        int close_list[NUM_PHASES];
        int idle_list[NUM_PHASES];
        int stall_list[NUM_PHASES];

        clk                = 1'b0;
        rst_n              = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        s_axis_tuser       = '0;
        cfg_valid          = 1'b0;
        cfg_index          = CFG_OPEN;
        cfg_data           = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_asks          = 0;
        open_cfg           = int'(OPEN_RESET);
        close_cfg          = int'(CLOSE_RESET);

        // Threshold settings per phase: both extremes, a wide split, an
        // inverted pair, the reset values and random ones. A negative entry
        // means a random value.
        open_list  = '{0, 255, 200, -1, 110, -1, 1, -1};
        close_list = '{0, 255, 40, -1, 100, -1, 254, -1};
        idle_list  = '{0, 58, 0, 35, 0, 58, 0, 35};
        stall_list = '{0, 0, 58, 35, 0, 0, 58, 35};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks with the reset thresholds and no gaps. A skipped
        // tick with every reading at its maximum comes first and must leave
        // no trace. The first active tick always strobes, and with the reset
        // averages it scores low, so it also shows a positive step written
        // with unchanged thresholds.
        send_tick(1'b0, 9'd511, 8'd255, 8'd255);
        send_tick(1'b1, 9'd0, 8'd0, 8'd0);
        send_tick(1'b1, 9'd511, 8'd255, 8'd255);
        send_tick(1'b0, 9'd0, 8'd0, 8'd0);
        // A clean voice run climbs toward the tightest step.
        repeat (14) send_tick(1'b1, 9'd511, 8'd0, 8'd8);
        // Pure noise afterwards: the hangover holds the score at its middle.
        repeat (6) send_tick(1'b1, 9'd0, 8'd255, 8'd255);
        send_tick(1'b1, 9'd256, 8'd128, 8'd128);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Skipped ticks may still be in flight when the last result beat
            // has come, so the bench waits before the registers change.
            repeat (4) @(posedge clk);
            write_thresholds((open_list[p] < 0) ? int'($urandom_range(255)) : open_list[p],
                             (close_list[p] < 0) ? int'($urandom_range(255)) : close_list[p]);
            sender_idle_pct     = idle_list[p];
            receiver_stall_pct <= stall_list[p];
            // In the first phase the receiver holds off for a long stretch
            // while the sender keeps offering beats, so the block fills up
            // and has to stall its input.
            if (p == 0)
                hold_asks <= hold_asks + 1;
            random_phase(PHASE_TICKS);
            s_axis_tvalid <= 1'b0;
            // The sender pauses here until every expected result has come.
            wait_drained();
        end

        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/vasa_pkg.sv
sv/vasa_smooth.sv
sv/vasa_score.sv
sv/voice_activity_squelch_adjust_core.sv
tb/sv/squelch_checker.sv
tb/sv/tb.sv
